// ----- rtl/ics_pkg.sv -----
package ics_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_packet;
      logic [1:0] packet_kind;
   } req_type;

   typedef struct packed {
      logic [15:0] checksum_value;
      logic [15:0] byte_count;
   } rsp_type;

   localparam logic [1:0]  KIND_UDP   = 2'd1;
   localparam logic [1:0]  KIND_TCP   = 2'd2;
   localparam logic [15:0] PROTO_UDP  = 16'd17;
   localparam logic [15:0] PROTO_TCP  = 16'd6;
   localparam logic [15:0] PSEUDO_SUB = 16'd8;

   // ones' complement add with end-around carry
   function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] term);
      logic [16:0] s;
      s = {1'b0, acc} + {1'b0, term};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage

// ----- rtl/internet_checksum_stream_core.sv -----
// Streaming Internet checksum over a packet delivered one byte per item.
// Input channel (req_): req_data carries the byte, the end-of-packet mark and
// the packet kind (0 IP, 1 UDP, 2 TCP, 3 as IP); the kind is taken from the
// first byte of each packet. Bytes pair big-endian into 16-bit words.
// Result channel (rsp_): one item per packet, issued for its final byte, with
// the ones' complement checksum and the byte count (saturating at
// 2^LENGTH_BITS - 1). UDP and TCP add the protocol number and count - 8.
// A final byte accepted into the input register moves into the result register
// as soon as that register is free to take it; rsp_valid rises with the load.
// Throughput: one byte per cycle while req_stall is low; the running sum updates
// with one 16-bit end-around-carry add per byte, closing adds in the same stage.
// Receiver stall: the result register holds its item; the input register
// keeps taking bytes that give no result, and req_stall rises only when a
// final byte waits behind a stalled result.
// Reset (synchronous, active high) empties both registers and drops any
// partly received packet.
module internet_checksum_stream_core #(
   parameter int LENGTH_BITS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  ics_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output ics_pkg::rsp_type rsp_data
);
   import ics_pkg::*;

   localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

   logic                   in_valid_ff;
   req_type                in_item_ff;
   logic [15:0]            sum_ff, sum_in;
   logic [7:0]             hold_ff, hold_in;
   logic                   odd_ff, odd_in;
   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic [1:0]             kind_ff, kind_in;
   logic                   open_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_item_ff, rsp_item_in;

   logic out_free;
   logic advance;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!in_item_ff.end_of_packet || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_item_ff;

   always_comb begin
      logic [15:0]            eff_sum;
      logic [7:0]             eff_hold;
      logic                   eff_odd;
      logic [LENGTH_BITS-1:0] eff_count;
      logic [15:0]            fin_sum;
      logic [15:0]            len_term;
      eff_sum   = open_ff ? sum_ff : 16'd0;
      eff_hold  = open_ff ? hold_ff : 8'd0;
      eff_odd   = open_ff ? odd_ff : 1'b0;
      eff_count = open_ff ? count_ff : '0;
      kind_in   = open_ff ? kind_ff : in_item_ff.packet_kind;
      if (eff_odd) begin
         sum_in  = ones_add(eff_sum, {eff_hold, in_item_ff.data_byte});
         hold_in = 8'd0;
         odd_in  = 1'b0;
      end else begin
         sum_in  = eff_sum;
         hold_in = in_item_ff.data_byte;
         odd_in  = 1'b1;
      end
      count_in = (eff_count == COUNT_MAX) ? eff_count : eff_count + LENGTH_BITS'(1);
      len_term = 16'(count_in) - PSEUDO_SUB;
      fin_sum  = odd_in ? ones_add(sum_in, {hold_in, 8'd0}) : sum_in;
      if (kind_in == KIND_UDP || kind_in == KIND_TCP) begin
         fin_sum = ones_add(fin_sum, (kind_in == KIND_UDP) ? PROTO_UDP : PROTO_TCP);
         fin_sum = ones_add(fin_sum, len_term);
      end
      rsp_item_in.checksum_value = ~fin_sum;
      rsp_item_in.byte_count     = 16'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         in_item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= 16'd0;
         hold_ff  <= 8'd0;
         odd_ff   <= 1'b0;
         count_ff <= '0;
         kind_ff  <= 2'd0;
         open_ff  <= 1'b0;
      end else if (advance) begin
         sum_ff   <= sum_in;
         hold_ff  <= hold_in;
         odd_ff   <= odd_in;
         count_ff <= count_in;
         kind_ff  <= kind_in;
         open_ff  <= !in_item_ff.end_of_packet;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_item_ff.end_of_packet) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance && in_item_ff.end_of_packet) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

endmodule

// ----- rtl/ics_checker.sv -----
module ics_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input ics_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ics_pkg::rsp_type rsp_data
);
   import ics_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // input only stalls behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("input stalled with free result register");

   // a new result follows an accepted item through the input and result registers
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without accepted item");

   // every packet has at least one byte
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.byte_count != 16'd0)
      else $error("zero byte count");

endmodule

bind internet_checksum_stream_core ics_checker u_ics_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
